// ===== hdl/rae_pkg.sv =====
// ----------------------------------------------------------------------------
// rae_pkg: shared types and codes for the register ALU executor
// Op codes, status codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package rae_pkg;

  typedef enum logic [3:0] {
    OP_MOV = 4'd0, OP_SUB = 4'd1, OP_ADD = 4'd2, OP_MUL = 4'd3,
    OP_DIV = 4'd4, OP_INC = 4'd5, OP_DEC = 4'd6, OP_OR  = 4'd7,
    OP_AND = 4'd8, OP_XOR = 4'd9, OP_NOT = 4'd10, OP_NOP = 4'd11,
    OP_SHL = 4'd12, OP_SHR = 4'd13, OP_ROL = 4'd14, OP_ROR = 4'd15
  } op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIV0    = 2'd1;
  localparam logic [1:0] ST_DIV_OVF = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // latch input item, read operands
    logic exec;      // compute ALU result / set up divider
    logic div_step;  // one restoring divide step
    logic div_done;  // finish the divide (sign fix)
    logic commit;    // write register file, load output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_div;    // item is a divide needing iterations
    logic div_last;  // last divide step in progress
  } sts_t;

endpackage

// ===== hdl/rae_ctrl.sv =====
// ----------------------------------------------------------------------------
// rae_ctrl: sequencer for the register ALU executor
// Steps each item through load, execute, optional divide loop and sign fix, and commit.
// ----------------------------------------------------------------------------
module rae_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          out_busy,
  input  rae_pkg::sts_t sts,
  output rae_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_FIX, S_COMMIT} state_t;

  state_t state_r, state_nxt;

  // Accept only in idle
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.is_div ? S_DIV : S_COMMIT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.div_done = 1'b1;
        state_nxt    = S_COMMIT;
      end
      S_COMMIT: begin
        // Hold until the output register is free
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hdl/rae_dp.sv =====
// ----------------------------------------------------------------------------
// rae_dp: datapath of the register ALU executor
// Register file, operand latches, ALU, multiplier and restoring divider.
// ----------------------------------------------------------------------------
module rae_dp #(
  parameter int NUM_REGS   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rae_pkg::cmd_t        cmd,
  output rae_pkg::sts_t        sts,
  input  logic [3:0]           in_op,
  input  logic [2:0]           in_dest_reg,
  input  logic                 in_src_is_imm,
  input  logic [2:0]           in_src_reg,
  input  logic signed [31:0]   in_imm_value,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 out_wrote,
  output logic [2:0]           out_written_reg,
  output logic signed [31:0]   out_written_value,
  output logic [1:0]           out_status
);

  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CW = $clog2(DATA_WIDTH + 1);
  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [DATA_WIDTH-1:0] regs_r [NUM_REGS];

  rae_pkg::op_t op_r;
  logic [RW-1:0] dst_r, tgt_r;
  logic [DATA_WIDTH-1:0] d_r, s_r, a_r, res_r;
  logic wr_r;
  logic [1:0] st_r;
  // Divider
  logic [DATA_WIDTH-1:0] rem_r, quo_r, div_r;
  logic neg_r;
  logic [CW-1:0] cnt_r;

  // Wrap indexes modulo NUM_REGS by repeated compare and subtract
  function automatic logic [RW-1:0] ridx(input logic [2:0] i);
    logic [5:0] w;
    w = {3'b000, i};
    for (int k = 0; k < 4; k++)
      if (32'(w) >= NUM_REGS) w = w - 6'(NUM_REGS);
    return RW'(w);
  endfunction

  // Reduce a rotate count modulo DATA_WIDTH
  function automatic logic [CW-1:0] cmod(input logic [4:0] c);
    logic [5:0] w;
    w = {1'b0, c};
    for (int k = 0; k < 4; k++)
      if (32'(w) >= DATA_WIDTH) w = w - 6'(DATA_WIDTH);
    return CW'(w);
  endfunction

  logic [DATA_WIDTH-1:0] imm_x;
  assign imm_x = DATA_WIDTH'(in_imm_value);

  logic [4:0] sh;
  logic [CW-1:0] shm;
  logic [2*DATA_WIDTH-1:0] dd;
  logic [DATA_WIDTH-1:0] alu, ua, ub;
  assign sh  = s_r[4:0];
  assign dd  = {d_r, d_r};
  assign shm = cmod(sh);
  assign ua  = a_r[DATA_WIDTH-1] ? -a_r : a_r;
  assign ub  = s_r[DATA_WIDTH-1] ? -s_r : s_r;

  // Combinational ALU
  always_comb begin
    case (op_r)
      rae_pkg::OP_MOV: alu = s_r;
      rae_pkg::OP_SUB: alu = d_r - s_r;
      rae_pkg::OP_ADD: alu = d_r + s_r;
      rae_pkg::OP_MUL: alu = a_r * s_r;
      rae_pkg::OP_INC: alu = d_r + 1'b1;
      rae_pkg::OP_DEC: alu = d_r - 1'b1;
      rae_pkg::OP_OR:  alu = d_r | s_r;
      rae_pkg::OP_AND: alu = d_r & s_r;
      rae_pkg::OP_XOR: alu = d_r ^ s_r;
      rae_pkg::OP_NOT: alu = ~d_r;
      rae_pkg::OP_SHL: alu = (32'(sh) >= DATA_WIDTH) ? '0 : d_r << sh;
      rae_pkg::OP_SHR: alu = DATA_WIDTH'($signed(d_r) >>> sh);
      rae_pkg::OP_ROL: alu = dd[2*DATA_WIDTH-1-shm -: DATA_WIDTH];
      rae_pkg::OP_ROR: alu = dd[shm +: DATA_WIDTH];
      default:         alu = '0;
    endcase
  end

  assign sts.is_div   = (op_r == rae_pkg::OP_DIV) && (st_r == rae_pkg::ST_OK);
  assign sts.div_last = (cnt_r == CW'(1));

  // Restoring divide step
  logic [DATA_WIDTH:0] trial;
  logic [DATA_WIDTH-1:0] rsh;
  assign rsh   = {rem_r[DATA_WIDTH-2:0], quo_r[DATA_WIDTH-1]};
  assign trial = {1'b0, rsh} - {1'b0, div_r};

  always_ff @(posedge clk) begin
    // Latch item and read operands
    if (cmd.load) begin
      op_r  <= rae_pkg::op_t'(in_op);
      dst_r <= ridx(in_dest_reg);
      d_r   <= regs_r[ridx(in_dest_reg)];
      s_r   <= in_src_is_imm ? imm_x : regs_r[ridx(in_src_reg)];
      a_r   <= regs_r[0];
      st_r  <= rae_pkg::ST_OK;
      if (in_op == rae_pkg::OP_DIV) begin
        if ((in_src_is_imm ? imm_x : regs_r[ridx(in_src_reg)]) == '0)
          st_r <= rae_pkg::ST_DIV0;
        else if (regs_r[0] == MINV &&
                 (in_src_is_imm ? imm_x : regs_r[ridx(in_src_reg)]) == '1)
          st_r <= rae_pkg::ST_DIV_OVF;
      end
    end
    // Compute result or start divider
    if (cmd.exec) begin
      res_r <= alu;
      wr_r  <= (op_r != rae_pkg::OP_NOP) && (op_r != rae_pkg::OP_DIV);
      tgt_r <= (op_r == rae_pkg::OP_MUL || op_r == rae_pkg::OP_DIV) ? '0 : dst_r;
      quo_r <= ua;
      rem_r <= '0;
      div_r <= ub;
      neg_r <= a_r[DATA_WIDTH-1] ^ s_r[DATA_WIDTH-1];
      cnt_r <= CW'(DATA_WIDTH);
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r - 1'b1;
      if (!trial[DATA_WIDTH]) begin
        rem_r <= trial[DATA_WIDTH-1:0];
        quo_r <= {quo_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= rsh;
        quo_r <= {quo_r[DATA_WIDTH-2:0], 1'b0};
      end
    end
    if (cmd.div_done) begin
      res_r <= neg_r ? -quo_r : quo_r;
      wr_r  <= 1'b1;
    end
  end

  // Write back on commit, clear at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (cmd.commit && wr_r) begin
      regs_r[tgt_r] <= res_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_wrote         <= wr_r;
      out_written_reg   <= wr_r ? 3'(tgt_r) : 3'd0;
      out_written_value <= wr_r ? 32'(res_r) : 32'sd0;
      out_status        <= st_r;
    end
  end

endmodule

// ===== hdl/register_alu_executor_core.sv =====
// ----------------------------------------------------------------------------
// register_alu_executor_core: decoded-instruction executor with register file
// Runs one instruction per item against NUM_REGS registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one decoded instruction per item, valid/stall.
//   Output channel (out_*): exactly one result item per instruction.
//   Items are taken one at a time; in_stall is high while one is in work.
//   Ops other than div pass through load, execute and commit.
//   Div adds DATA_WIDTH restoring steps, one quotient bit per cycle, then
//   a sign fix before commit.
//   Divide by zero and overflow skip the loop and the sign fix.
//   The result sits in an output register; the next item is accepted
//   while it waits. A commit holds while the output register is still full
//   and stalled, which also holds the register file write.
//   Reset (rst_n low, synchronous) clears all registers to zero and drops
//   out_valid.
module register_alu_executor_core #(
  parameter int NUM_REGS   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          in_op,
  input  logic [2:0]          in_dest_reg,
  input  logic                in_src_is_imm,
  input  logic [2:0]          in_src_reg,
  input  logic signed [31:0]  in_imm_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_wrote,
  output logic [2:0]          out_written_reg,
  output logic signed [31:0]  out_written_value,
  output logic [1:0]          out_status
);

  rae_pkg::cmd_t cmd;
  rae_pkg::sts_t sts;

  rae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_valid && out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rae_dp #(.NUM_REGS(NUM_REGS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_dest_reg       (in_dest_reg),
    .in_src_is_imm     (in_src_is_imm),
    .in_src_reg        (in_src_reg),
    .in_imm_value      (in_imm_value),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_wrote         (out_wrote),
    .out_written_reg   (out_written_reg),
    .out_written_value (out_written_value),
    .out_status        (out_status)
  );

endmodule

// ===== hdl/rae_checker.sv =====
// ----------------------------------------------------------------------------
// rae_checker: port-level checks for the register ALU executor
// Watches the handshakes and result codes over time.
// ----------------------------------------------------------------------------
module rae_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_wrote,
  input logic [2:0]  out_written_reg,
  input logic [1:0]  out_status
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // Busy right after accepting an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted without going busy");

  // Error status never writes
  a_err_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rae_pkg::ST_OK |-> !out_wrote)
    else $error("error result wrote a register");

  // Results that write no register report index zero
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_wrote |-> out_written_reg == 3'd0)
    else $error("nonzero index without write");

endmodule

bind register_alu_executor_core rae_checker u_rae_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_wrote       (out_wrote),
  .out_written_reg (out_written_reg),
  .out_status      (out_status)
);
